// ===== rtl/core/tbq_pkg.sv =====
// Shared types, constants and register codes for the three-axis biquad lowpass.
`timescale 1ns / 1ps
package tbq_pkg;

  localparam int AXES_DEFAULT = 3;
  localparam int NUM_FIELDS   = 3;

  localparam int SMP_W   = 16;
  localparam int COEF_W  = 16;
  localparam int SHIFT_W = 5;
  localparam int HIST_W  = 32;
  localparam int PROD_W  = COEF_W + HIST_W;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;

  localparam logic signed [COEF_W-1:0] RST_COEF_OLDER  = -16'sd937;
  localparam logic [SHIFT_W-1:0]       RST_SHIFT_OLDER = 5'd10;
  localparam logic signed [COEF_W-1:0] RST_COEF_NEWER  = 16'sd1957;
  localparam logic [SHIFT_W-1:0]       RST_SHIFT_NEWER = 5'd10;
  localparam logic signed [COEF_W-1:0] RST_GAIN        = 16'sd31;
  localparam logic [SHIFT_W-1:0]       RST_IN_SHIFT    = 5'd6;
  localparam logic [SHIFT_W-1:0]       RST_OUT_SHIFT   = 5'd9;

  typedef enum logic [IDX_W-1:0] {
    REG_FB_COEF_OLDER  = 3'd0,
    REG_FB_SHIFT_OLDER = 3'd1,
    REG_FB_COEF_NEWER  = 3'd2,
    REG_FB_SHIFT_NEWER = 3'd3,
    REG_OUTPUT_GAIN    = 3'd4,
    REG_INPUT_SHIFT    = 3'd5,
    REG_OUTPUT_SHIFT   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_older;
    logic [SHIFT_W-1:0]       shift_older;
    logic signed [COEF_W-1:0] coef_newer;
    logic [SHIFT_W-1:0]       shift_newer;
    logic signed [COEF_W-1:0] gain;
    logic [SHIFT_W-1:0]       in_shift;
    logic [SHIFT_W-1:0]       out_shift;
  } cfg_t;

  // Sequencer steps broadcast to every lane.
  typedef struct packed {
    logic load;
    logic mul_old;
    logic mul_new;
    logic sum;
    logic mul_gain;
  } step_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] value;
    logic                    clip;
  } lane_res_t;

endpackage

// ===== rtl/core/tbq_in_if.sv =====
// Sample request channel: valid/ready plus one sample per axis.
`timescale 1ns / 1ps
interface tbq_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [tbq_pkg::SMP_W-1:0] sample_x;
  logic signed [tbq_pkg::SMP_W-1:0] sample_y;
  logic signed [tbq_pkg::SMP_W-1:0] sample_z;

  modport source (output valid, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

// ===== rtl/core/tbq_out_if.sv =====
// Result request channel: valid/ready plus filtered axes and clip mask.
`timescale 1ns / 1ps
interface tbq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tbq_pkg::SMP_W-1:0]      filtered_x;
  logic signed [tbq_pkg::SMP_W-1:0]      filtered_y;
  logic signed [tbq_pkg::SMP_W-1:0]      filtered_z;
  logic [tbq_pkg::NUM_FIELDS-1:0]        clipped_mask;

  modport source (output valid, filtered_x, filtered_y, filtered_z, clipped_mask,
                  input ready);
  modport sink   (input valid, filtered_x, filtered_y, filtered_z, clipped_mask,
                  output ready);
endinterface

// ===== rtl/core/tbq_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
`timescale 1ns / 1ps
interface tbq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tbq_pkg::IDX_W-1:0]   index;
  logic [tbq_pkg::DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/three_axis_biquad_lowpass.sv =====
// A result request is registered in the merge after the lanes pass the old, new, sum,
// gain and final steps; a new sample request is taken only in the idle step. Each lane's
// single multiplier forms three products per sample in turn.
// A result not yet taken holds the lanes in their final step.
// Reset: filter history cleared, registers to defaults, no result pending.
`timescale 1ns / 1ps
module three_axis_biquad_lowpass #(
  parameter int AXES = tbq_pkg::AXES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tbq_in_if.sink     samples,
  tbq_out_if.source  results,
  tbq_cfg_if.sink    cfg
);

  localparam int LANES = (AXES < tbq_pkg::NUM_FIELDS) ? AXES : tbq_pkg::NUM_FIELDS;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_OLD  = 6'b000010,
    ST_NEW  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_GAIN = 6'b010000,
    ST_SAT  = 6'b100000
  } state_t;

  state_t             state, state_next;
  tbq_pkg::cfg_t      regs;
  tbq_pkg::step_t     step;
  tbq_pkg::lane_res_t lane_res [LANES];
  logic               load_ok;
  logic               accept;
  logic               merge_load;
  logic signed [tbq_pkg::SMP_W-1:0] smp [tbq_pkg::NUM_FIELDS];

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coef_older  <= tbq_pkg::RST_COEF_OLDER;
      regs.shift_older <= tbq_pkg::RST_SHIFT_OLDER;
      regs.coef_newer  <= tbq_pkg::RST_COEF_NEWER;
      regs.shift_newer <= tbq_pkg::RST_SHIFT_NEWER;
      regs.gain        <= tbq_pkg::RST_GAIN;
      regs.in_shift    <= tbq_pkg::RST_IN_SHIFT;
      regs.out_shift   <= tbq_pkg::RST_OUT_SHIFT;
    end else if (cfg.valid) begin
      case (tbq_pkg::reg_idx_t'(cfg.index))
        tbq_pkg::REG_FB_COEF_OLDER:  regs.coef_older  <= cfg.data;
        tbq_pkg::REG_FB_SHIFT_OLDER: regs.shift_older <= cfg.data[tbq_pkg::SHIFT_W-1:0];
        tbq_pkg::REG_FB_COEF_NEWER:  regs.coef_newer  <= cfg.data;
        tbq_pkg::REG_FB_SHIFT_NEWER: regs.shift_newer <= cfg.data[tbq_pkg::SHIFT_W-1:0];
        tbq_pkg::REG_OUTPUT_GAIN:    regs.gain        <= cfg.data;
        tbq_pkg::REG_INPUT_SHIFT:    regs.in_shift    <= cfg.data[tbq_pkg::SHIFT_W-1:0];
        tbq_pkg::REG_OUTPUT_SHIFT:   regs.out_shift   <= cfg.data[tbq_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step sequencer shared by all lanes.
  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign merge_load    = (state == ST_SAT) && load_ok;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_OLD;
      ST_OLD:  state_next = ST_NEW;
      ST_NEW:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_SAT;
      ST_SAT:  if (load_ok) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign step.load     = accept;
  assign step.mul_old  = (state == ST_OLD);
  assign step.mul_new  = (state == ST_NEW);
  assign step.sum      = (state == ST_SUM);
  assign step.mul_gain = (state == ST_GAIN);

  assign smp[0] = samples.sample_x;
  assign smp[1] = samples.sample_y;
  assign smp[2] = samples.sample_z;

  for (genvar a = 0; a < LANES; a++) begin : g_lane
    tbq_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .step   (step),
      .cfg    (regs),
      .sample (smp[a]),
      .res    (lane_res[a])
    );
  end

  tbq_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk     (clk),
    .rst     (rst),
    .load    (merge_load),
    .res     (lane_res),
    .load_ok (load_ok),
    .results (results)
  );

`ifndef SYNTH
  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |-> ##5 (state == ST_SAT))
    else $error("sequencer did not reach final step five cycles after a request");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAT) && load_ok |=> results.valid && (state == ST_IDLE))
    else $error("lane results not presented after final step");

  a_clip_x: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.clipped_mask[0] |->
      (results.filtered_x == 16'sh7fff) || (results.filtered_x == 16'sh8000))
    else $error("x clip flag set on a value that is not a rail");
`endif

endmodule

// ===== rtl/core/tbq_lane.sv =====
// One axis of the filter: history registers and a shared 16x32 multiplier.
`timescale 1ns / 1ps
module tbq_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  tbq_pkg::step_t                   step,
  input  tbq_pkg::cfg_t                    cfg,
  input  logic signed [tbq_pkg::SMP_W-1:0] sample,
  output tbq_pkg::lane_res_t               res
);

  localparam int SW = tbq_pkg::SMP_W;
  localparam int HW = tbq_pkg::HIST_W;
  localparam int PW = tbq_pkg::PROD_W;

  logic signed [SW-1:0] v;
  logic [HW-1:0]        x1, x2;
  logic signed [HW-1:0] y1, y2;
  logic [HW-1:0]        acc;
  logic signed [PW-1:0] prod;

  logic signed [tbq_pkg::COEF_W-1:0] mul_coef;
  logic signed [HW-1:0]              mul_opnd;
  logic signed [PW-1:0]              mul_out;
  logic signed [PW-1:0]              fb_old, fb_new, scaled;
  logic [HW-1:0]                     y_next;
  logic                              over;

  always_comb begin
    mul_coef = cfg.gain;
    mul_opnd = y1;
    if (step.mul_old) begin
      mul_coef = cfg.coef_older;
      mul_opnd = y2;
    end else if (step.mul_new) begin
      mul_coef = cfg.coef_newer;
      mul_opnd = y1;
    end
  end

  assign mul_out = PW'(mul_coef) * PW'(mul_opnd);
  assign fb_old  = prod >>> cfg.shift_older;
  assign fb_new  = prod >>> cfg.shift_newer;
  assign y_next  = acc + {{(HW-SW){v[SW-1]}}, v} + fb_new[HW-1:0];

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (step.load) begin
      v <= sample >>> cfg.in_shift;
    end
    if (step.mul_old || step.mul_new || step.mul_gain) begin
      prod <= mul_out;
    end
    if (step.mul_new) begin
      acc <= fb_old[HW-1:0] + x2 + {x1[HW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (step.sum) begin
      x2 <= x1;
      x1 <= {{(HW-SW){v[SW-1]}}, v};
      y2 <= y1;
      y1 <= y_next;
    end
  end

  // Final scale and saturate, read while the gain product is held.
  assign scaled = prod >>> cfg.out_shift;
  assign over   = (scaled[PW-1:SW-1] != {(PW-SW+1){1'b0}}) &&
                  (scaled[PW-1:SW-1] != {(PW-SW+1){1'b1}});

  always_comb begin
    res.clip  = over;
    res.value = scaled[SW-1:0];
    if (over) begin
      res.value = scaled[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/core/tbq_merge.sv =====
// Output register: gathers the lane results into one result request.
`timescale 1ns / 1ps
module tbq_merge #(
  parameter int LANES = tbq_pkg::NUM_FIELDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tbq_pkg::lane_res_t res [LANES],
  output logic               load_ok,
  tbq_out_if.source          results
);

  localparam int NF = tbq_pkg::NUM_FIELDS;

  logic                               valid;
  logic signed [tbq_pkg::SMP_W-1:0]   field [NF];
  logic [NF-1:0]                      mask;
  logic signed [tbq_pkg::SMP_W-1:0]   field_next [NF];
  logic [NF-1:0]                      mask_next;

  // Axes without a lane report zero.
  for (genvar i = 0; i < NF; i++) begin : g_field
    if (i < LANES) begin : g_lane
      assign field_next[i] = res[i].value;
      assign mask_next[i]  = res[i].clip;
    end else begin : g_none
      assign field_next[i] = '0;
      assign mask_next[i]  = 1'b0;
    end
  end

  assign load_ok = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      field <= field_next;
      mask  <= mask_next;
    end
  end

  assign results.valid        = valid;
  assign results.filtered_x   = field[0];
  assign results.filtered_y   = field[1];
  assign results.filtered_z   = field[2];
  assign results.clipped_mask = mask;

endmodule

// ===== tb/three_axis_biquad_lowpass_check.sv =====
// Watches the sample, result and register channels, predicts every filtered result and compares.
`timescale 1ns / 1ps
module three_axis_biquad_lowpass_check #(
  parameter int AXES = tbq_pkg::AXES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  tbq_in_if    samples,
  tbq_out_if   results,
  tbq_cfg_if   cfg,
  output int   fail_count,
  output int   outstanding,
  output int   compared,
  output int   saturated
);
  import tbq_pkg::*;

  typedef struct packed {
    logic signed [SMP_W-1:0] fx;
    logic signed [SMP_W-1:0] fy;
    logic signed [SMP_W-1:0] fz;
    logic [NUM_FIELDS-1:0]   mask;
  } filtered_t;

  cfg_t                     settings;
  logic signed [HIST_W-1:0] x_hist [2*AXES];
  logic signed [HIST_W-1:0] y_hist [2*AXES];
  filtered_t                expected_filtered [$];
  int                       fails;
  int                       n_compared;
  int                       n_saturated;

  // One axis of the biquad; updates that axis's history.
  function automatic lane_res_t filter_axis(int a, logic signed [SMP_W-1:0] raw);
    logic signed [COEF_W-1:0] c_old;
    logic signed [COEF_W-1:0] c_new;
    logic signed [COEF_W-1:0] gain;
    logic signed [HIST_W-1:0] v;
    logic signed [HIST_W-1:0] fb_old;
    logic signed [HIST_W-1:0] fb_new;
    logic signed [HIST_W-1:0] y;
    logic signed [PROD_W-1:0] p_old;
    logic signed [PROD_W-1:0] p_new;
    logic signed [PROD_W-1:0] p_gain;
    lane_res_t                res;
    c_old  = settings.coef_older;
    c_new  = settings.coef_newer;
    gain   = settings.gain;
    v      = HIST_W'(raw);
    v      = v >>> settings.in_shift;
    // shift at full precision, then wrap to the history width
    p_old  = PROD_W'(c_old) * PROD_W'(y_hist[2*a]);
    p_old  = p_old >>> settings.shift_older;
    fb_old = p_old[HIST_W-1:0];
    p_new  = PROD_W'(c_new) * PROD_W'(y_hist[2*a+1]);
    p_new  = p_new >>> settings.shift_newer;
    fb_new = p_new[HIST_W-1:0];
    y = x_hist[2*a] + v + (x_hist[2*a+1] <<< 1) + fb_old + fb_new;
    x_hist[2*a]   = x_hist[2*a+1];
    x_hist[2*a+1] = v;
    y_hist[2*a]   = y_hist[2*a+1];
    y_hist[2*a+1] = y;
    p_gain = PROD_W'(y) * PROD_W'(gain);
    p_gain = p_gain >>> settings.out_shift;
    if (p_gain > 32767) begin
      res.value = 16'sh7fff;
      res.clip  = 1'b1;
    end else if (p_gain < -32768) begin
      res.value = 16'sh8000;
      res.clip  = 1'b1;
    end else begin
      res.value = p_gain[SMP_W-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

  function automatic filtered_t predict_filtered(logic signed [SMP_W-1:0] sx,
                                                 logic signed [SMP_W-1:0] sy,
                                                 logic signed [SMP_W-1:0] sz);
    logic signed [SMP_W-1:0] raw [NUM_FIELDS];
    lane_res_t               lane;
    filtered_t               f;
    int                      a;
    raw[0] = sx;
    raw[1] = sy;
    raw[2] = sz;
    f = '0;
    // axes the block does not have stay zero
    for (a = 0; a < NUM_FIELDS && a < AXES; a++) begin
      lane = filter_axis(a, raw[a]);
      f.mask[a] = lane.clip;
      case (a)
        0: f.fx = lane.value;
        1: f.fy = lane.value;
        default: f.fz = lane.value;
      endcase
    end
    return f;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    filtered_t want;
    int        i;
    if (rst) begin
      settings.coef_older  = RST_COEF_OLDER;
      settings.shift_older = RST_SHIFT_OLDER;
      settings.coef_newer  = RST_COEF_NEWER;
      settings.shift_newer = RST_SHIFT_NEWER;
      settings.gain        = RST_GAIN;
      settings.in_shift    = RST_IN_SHIFT;
      settings.out_shift   = RST_OUT_SHIFT;
      for (i = 0; i < 2*AXES; i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      expected_filtered.delete();
      fails       = 0;
      n_compared  = 0;
      n_saturated = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_FB_COEF_OLDER:  settings.coef_older  = cfg.data;
          REG_FB_SHIFT_OLDER: settings.shift_older = cfg.data[SHIFT_W-1:0];
          REG_FB_COEF_NEWER:  settings.coef_newer  = cfg.data;
          REG_FB_SHIFT_NEWER: settings.shift_newer = cfg.data[SHIFT_W-1:0];
          REG_OUTPUT_GAIN:    settings.gain        = cfg.data;
          REG_INPUT_SHIFT:    settings.in_shift    = cfg.data[SHIFT_W-1:0];
          REG_OUTPUT_SHIFT:   settings.out_shift   = cfg.data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (expected_filtered.size() == 0) begin
          fails++;
          $display("%0t: result request with nothing expected: x=%0d y=%0d z=%0d mask=%0d",
                   $time, results.filtered_x, results.filtered_y, results.filtered_z,
                   results.clipped_mask);
        end else begin
          want = expected_filtered.pop_front();
          n_compared++;
          n_saturated += $countones(want.mask);
          compare_field("filtered_x", want.fx, results.filtered_x);
          compare_field("filtered_y", want.fy, results.filtered_y);
          compare_field("filtered_z", want.fz, results.filtered_z);
          compare_field("clipped_mask", want.mask, results.clipped_mask);
        end
      end
      if (samples.valid && samples.ready)
        expected_filtered.push_back(predict_filtered(samples.sample_x, samples.sample_y,
                                                     samples.sample_z));
    end
    fail_count  <= fails;
    outstanding <= expected_filtered.size();
    compared    <= n_compared;
    saturated   <= n_saturated;
  end

endmodule

// ===== tb/three_axis_biquad_lowpass_test.sv =====
// Top of the lowpass testbench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 1ps
module three_axis_biquad_lowpass_test;
  import tbq_pkg::*;

  localparam int                 NUM_RANDOM    = 1700;
  localparam int                 PHASES        = 10;
  localparam int                 SETTLE_CYCLES = 12;
  localparam int                 LONG_HOLD     = 150;
  localparam logic [IDX_W-1:0]   REG_SPARE     = 3'd7;

  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left;
  int   send_idle_pct;
  int   take_idle_pct;
  int   fail_count;
  int   outstanding;
  int   compared;
  int   saturated;
  int   sent;
  int   settings_used;
  logic signed [SMP_W-1:0] last_smp [NUM_FIELDS];

  tbq_in_if  samples ();
  tbq_out_if results ();
  tbq_cfg_if cfg ();

  three_axis_biquad_lowpass uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  three_axis_biquad_lowpass_check filter_check (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .compared    (compared),
    .saturated   (saturated)
  );

  always #1 clk = ~clk;

  // Result side: random stalls, plus one long hold when the toggle flips.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= LONG_HOLD;
      results.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  task automatic send_sample(logic signed [SMP_W-1:0] sx, logic signed [SMP_W-1:0] sy,
                             logic signed [SMP_W-1:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid    <= 1'b1;
    samples.sample_x <= sx;
    samples.sample_y <= sy;
    samples.sample_z <= sz;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sent++;
  endtask

  // Drop the request, drain every pending result, then let the pipeline empty.
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t s);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'($urandom);
    settle();
    // shift registers get random upper bits, which must be ignored
    write_reg(REG_FB_COEF_OLDER, s.coef_older);
    write_reg(REG_FB_SHIFT_OLDER, {junk[DATA_W-1:SHIFT_W], s.shift_older});
    write_reg(REG_FB_COEF_NEWER, s.coef_newer);
    write_reg(REG_FB_SHIFT_NEWER, {~junk[DATA_W-1:SHIFT_W], s.shift_newer});
    write_reg(REG_OUTPUT_GAIN, s.gain);
    write_reg(REG_INPUT_SHIFT, {junk[DATA_W-1:SHIFT_W], s.in_shift});
    write_reg(REG_OUTPUT_SHIFT, {~junk[DATA_W-1:SHIFT_W], s.out_shift});
    write_reg(REG_SPARE, junk);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [SMP_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  // Mostly smooth or held signals so the filter settles; some noise and extremes.
  task automatic send_random();
    logic signed [SMP_W-1:0] v [NUM_FIELDS];
    int                      kind;
    int                      a;
    kind = $urandom_range(9);
    for (a = 0; a < NUM_FIELDS; a++) begin
      case (kind)
        0, 1, 2: v[a] = SMP_W'($urandom);
        3, 4, 5: v[a] = last_smp[a] + 16'($urandom_range(1023)) - 16'sd512;
        6, 7:    v[a] = last_smp[a];
        8:       v[a] = pick_extreme();
        default: v[a] = SMP_W'($urandom_range(127) - 64);
      endcase
    end
    last_smp = v;
    send_sample(v[0], v[1], v[2]);
  endtask

  function automatic cfg_t random_settings(bit tame);
    cfg_t s;
    if (tame) begin
      s.coef_older  = COEF_W'(-16'sd1000 + $urandom_range(200));
      s.shift_older = 5'd10;
      s.coef_newer  = COEF_W'(16'sd1800 + $urandom_range(200));
      s.shift_newer = 5'd10;
      s.gain        = COEF_W'($urandom_range(127) - 64);
      s.in_shift    = SHIFT_W'($urandom_range(8));
      s.out_shift   = SHIFT_W'($urandom_range(14, 4));
    end else begin
      s.coef_older  = COEF_W'($urandom);
      s.shift_older = SHIFT_W'($urandom);
      s.coef_newer  = COEF_W'($urandom);
      s.shift_newer = SHIFT_W'($urandom);
      s.gain        = COEF_W'($urandom);
      s.in_shift    = SHIFT_W'($urandom);
      s.out_shift   = SHIFT_W'($urandom);
    end
    return s;
  endfunction

  initial begin
    cfg_t plan [PHASES];
    int   p;
    int   i;
    samples.valid    = 1'b0;
    samples.sample_x = '0;
    samples.sample_y = '0;
    samples.sample_z = '0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    send_idle_pct    = 37;
    take_idle_pct    = 46;
    sent             = 0;
    settings_used    = 1;
    for (i = 0; i < NUM_FIELDS; i++) last_smp[i] = '0;

    plan[0] = '{coef_older: -16'sd980, shift_older: 5'd10, coef_newer: 16'sd2003,
                shift_newer: 5'd10, gain: 16'sd31, in_shift: 5'd6, out_shift: 5'd9};
    // full-scale feedback: sums wrap, outputs saturate
    plan[1] = '{coef_older: 16'sh8000, shift_older: 5'd31, coef_newer: 16'sh7fff,
                shift_newer: 5'd0, gain: 16'sh8000, in_shift: 5'd0, out_shift: 5'd0};
    plan[2] = '{coef_older: 16'sh7fff, shift_older: 5'd0, coef_newer: 16'sh8000,
                shift_newer: 5'd31, gain: 16'sh7fff, in_shift: 5'd31, out_shift: 5'd31};
    for (p = 3; p < PHASES - 1; p++) plan[p] = random_settings(p[0]);
    plan[PHASES-1] = '{coef_older: RST_COEF_OLDER, shift_older: RST_SHIFT_OLDER,
                       coef_newer: RST_COEF_NEWER, shift_newer: RST_SHIFT_NEWER,
                       gain: RST_GAIN, in_shift: RST_IN_SHIFT, out_shift: RST_OUT_SHIFT};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed samples on reset settings
    send_sample(16'sh7fff, 16'sh8000, 16'sh0000);
    send_sample(16'sh8000, 16'sh7fff, 16'shffff);
    send_sample(16'sh0001, 16'shffff, 16'sh0002);
    repeat (4) send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    repeat (4) send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    repeat (2) begin
      send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
      send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    end
    send_sample(16'sh5555, 16'shaaaa, 16'sh00ff);
    send_sample(16'shaaaa, 16'sh5555, 16'shff00);
    repeat (4) send_sample(16'sh0000, 16'sh0000, 16'sh0000);

    for (p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct = 46;
        take_idle_pct = 37;
      end else if (p == 6) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      apply_settings(plan[p]);
      // hold results off while requests keep coming
      if (p == PHASES - 1) hold_toggle <= ~hold_toggle;
      for (i = 0; i < NUM_RANDOM / PHASES; i++) send_random();
    end
    settle();

    $display("Sent %0d sample requests under %0d register settings;", sent, settings_used);
    $display("%0d results compared, %0d clipped axes.", compared, saturated);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", outstanding);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
